// File: design/rlpe_pkg.sv
// Shared types and constants for the RLP prefix encoder.
`default_nettype none

package rlpe_pkg;

   // Length bytes the long form may carry (saturating beyond this).
   localparam int LENGTH_BYTES = 4;
   // Payload length field is 32 bits, so at most four length bytes are ever needed.
   localparam int CAP_BYTES = (LENGTH_BYTES < 4) ? LENGTH_BYTES : 4;
   localparam int CAP_W     = 8 * CAP_BYTES;
   localparam int NLEN_W    = $clog2(CAP_BYTES + 1);
   localparam int STEP_W    = $clog2(CAP_BYTES + 2);
   localparam int LIDX_W    = (CAP_BYTES > 1) ? $clog2(CAP_BYTES) : 1;

   localparam logic [7:0] STRING_OFFSET = 8'h80;
   localparam logic [7:0] LIST_OFFSET   = 8'hC0;
   localparam logic [7:0] SINGLE_LIMIT  = 8'h80;
   localparam logic [31:0] SHORT_LIMIT  = 32'd56;
   localparam logic [7:0] LONG_BASE     = 8'd55;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified item: what the back end has to emit.
   typedef struct packed {
      logic                            has_prefix;
      logic [7:0]                      prefix_byte;
      logic [NLEN_W-1:0]               n_len;
      logic [CAP_BYTES-1:0][7:0]       len_bytes;
      logic [7:0]                      data_byte;
   } item_desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic mid_item;   // back end has emitted part of the head item
      logic pop;        // head item fully handed to the output register
   } back_status_type;

endpackage

`default_nettype wire

// File: design/rlpe_front.sv
// Front end: classifies one input byte into an emission descriptor.
`default_nettype none

module rlpe_front (
   input  wire logic                   item_kind,
   input  wire logic [31:0]            payload_length,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   starts_item,
   output rlpe_pkg::item_desc_type     desc
);

   logic [7:0]                       offset;
   logic [rlpe_pkg::CAP_W-1:0]       len_cap;
   logic [rlpe_pkg::NLEN_W-1:0]      n_len;
   logic [rlpe_pkg::CAP_BYTES-1:0][7:0] len_bytes;

   assign offset = item_kind ? rlpe_pkg::LIST_OFFSET : rlpe_pkg::STRING_OFFSET;

   // Saturate lengths wider than the length byte budget.
   always_comb begin
      if ((payload_length >> rlpe_pkg::CAP_W) != 32'd0) begin
         len_cap = '1;
      end else begin
         len_cap = payload_length[rlpe_pkg::CAP_W-1:0];
      end
      len_bytes = len_cap;
      n_len = '0;
      for (int i = 0; i < rlpe_pkg::CAP_BYTES; i++) begin
         if (len_bytes[i] != 8'd0) begin
            n_len = rlpe_pkg::NLEN_W'(i + 1);
         end
      end
   end

   always_comb begin
      desc             = '0;
      desc.data_byte   = data_byte;
      desc.len_bytes   = len_bytes;
      if (!starts_item) begin
         desc.has_prefix = 1'b0;
      end else if (payload_length == 32'd0) begin
         // empty item: offset alone
         desc.has_prefix = 1'b0;
         desc.data_byte  = offset;
      end else if (!item_kind && payload_length == 32'd1 && data_byte < rlpe_pkg::SINGLE_LIMIT) begin
         desc.has_prefix = 1'b0;
      end else if (payload_length < rlpe_pkg::SHORT_LIMIT) begin
         desc.has_prefix  = 1'b1;
         desc.prefix_byte = offset + payload_length[7:0];
      end else begin
         desc.has_prefix  = 1'b1;
         desc.n_len       = n_len;
         desc.prefix_byte = offset + rlpe_pkg::LONG_BASE + 8'(n_len);
      end
   end

endmodule

`default_nettype wire

// File: design/rlpe_queue.sv
// Short descriptor queue between front and back ends.
`default_nettype none

module rlpe_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire rlpe_pkg::item_desc_type    push_desc,
   input  wire logic                       pop,
   output rlpe_pkg::item_desc_type         head_desc,
   output rlpe_pkg::queue_status_type      status
);

   rlpe_pkg::item_desc_type entries_ff [rlpe_pkg::QUEUE_DEPTH];
   logic [rlpe_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rlpe_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rlpe_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == rlpe_pkg::QCNT_W'(rlpe_pkg::QUEUE_DEPTH));
   assign head_desc    = entries_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   function automatic logic [rlpe_pkg::QPTR_W-1:0] ptr_next(
      input logic [rlpe_pkg::QPTR_W-1:0] p);
      if (p == rlpe_pkg::QPTR_W'(rlpe_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// File: design/rlpe_back.sv
// Back end: serializes a descriptor into output bytes through the output register.
`default_nettype none

module rlpe_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rlpe_pkg::item_desc_type    head_desc,
   input  wire rlpe_pkg::queue_status_type q_status,
   output rlpe_pkg::back_status_type       status,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_run_last
);

   logic [rlpe_pkg::STEP_W-1:0] step_ff, step_in;
   logic [rlpe_pkg::STEP_W-1:0] last_step, n_ext, lidx_full;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  out_byte_ff, out_byte_in;
   logic                        run_last_ff, run_last_in;
   logic                        load, fire, at_last;

   assign n_ext     = rlpe_pkg::STEP_W'(head_desc.n_len);
   assign last_step = head_desc.has_prefix ? n_ext + 1'b1 : '0;
   assign at_last   = (step_ff == last_step);
   assign lidx_full = n_ext - step_ff;

   assign load = !rsp_valid_ff || rsp_ready;
   assign fire = load && !q_status.empty;

   always_comb begin
      if (head_desc.has_prefix && step_ff == '0) begin
         out_byte_in = head_desc.prefix_byte;
      end else if (!at_last) begin
         out_byte_in = head_desc.len_bytes[lidx_full[rlpe_pkg::LIDX_W-1:0]];
      end else begin
         out_byte_in = head_desc.data_byte;
      end
      run_last_in  = at_last;
      step_in      = fire ? (at_last ? '0 : step_ff + 1'b1) : step_ff;
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff <= out_byte_in;
         run_last_ff <= run_last_in;
      end
   end

   assign status.mid_item = (step_ff != '0);
   assign status.pop      = fire && at_last;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = run_last_ff;

endmodule

`default_nettype wire

// File: design/rlp_prefix_encoder_core.sv
// Top level of the RLP prefix encoder: front classifier, descriptor queue, byte serializer.
//
// Usage:
//   req_* channel carries one byte per transfer: item_kind, payload_length and
//   starts_item describe the item on its first byte; later bytes pass through.
//   rsp_* channel carries encoded bytes; rsp_run_last marks the last byte
//   produced by one request transfer.
// Path: with an empty queue, the request transfer writes the queue entry and the
//   output register then loads from the queue head, raising rsp_valid.
// Throughput: one output byte per cycle while rsp_ready is high. A pass-through
//   byte, a single small string byte or an empty item yields one byte; a short
//   item two; a long item 2 + n bytes, n the count of length bytes (1..4). The
//   serializer emits one byte per cycle from the head of a two-entry queue, so the
//   request side keeps flowing until the queue fills behind a multi-byte prefix.
// Reset: synchronous, clears queue pointers, serializer step and rsp_valid;
//   no item in flight survives.
// Stall: when rsp_ready is low with rsp_valid set the output register holds; the
//   serializer stops, the queue fills and req_ready drops once both entries are taken.
`default_nettype none

module rlp_prefix_encoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_item_kind,
   input  wire logic [31:0] req_payload_length,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_starts_item,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last
);

   rlpe_pkg::item_desc_type    front_desc;
   rlpe_pkg::item_desc_type    head_desc;
   rlpe_pkg::queue_status_type q_status;
   rlpe_pkg::back_status_type  back_status;
   logic                       req_xfer;

   // Ready only depends on queue space, never on serializer state.
   assign req_ready = !q_status.full;
   assign req_xfer  = req_valid && req_ready;

   rlpe_front u_front (
      .item_kind      (req_item_kind),
      .payload_length (req_payload_length),
      .data_byte      (req_data_byte),
      .starts_item    (req_starts_item),
      .desc           (front_desc)
   );

   rlpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_desc (front_desc),
      .pop       (back_status.pop),
      .head_desc (head_desc),
      .status    (q_status)
   );

   rlpe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_desc    (head_desc),
      .q_status     (q_status),
      .status       (back_status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

   // Serializer only pops an item that is present.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      back_status.pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // Partway through an item, its descriptor must still be at the head.
   a_mid_item_held: assert property (@(posedge clock) disable iff (reset)
      back_status.mid_item |-> !q_status.empty)
      else $error("serializer mid item with empty queue");

   // Output register is empty right after reset.
   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid set after reset");

   // A full queue with no output progress keeps the request side stalled.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (q_status.full && rsp_valid && !rsp_ready) |=> !req_ready)
      else $error("request accepted while stalled and full");

endmodule

`default_nettype wire
